/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante in a cycle implies cons in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* src/eoim_pkg.sv */
// ----------------------------------------------------------------------------
// eoim_pkg
// Shared constants and types for the element order / inverse core.
// ----------------------------------------------------------------------------
package eoim_pkg;

	// width of the modulus datapath
	localparam int MOD_BITS = 16;
	// width of the element, order and inverse fields
	localparam int FIELD_W  = 16;
	// bit counter for the serial multiplier, holds MOD_BITS itself
	localparam int CNT_W    = $clog2(MOD_BITS + 1);

	localparam logic [FIELD_W-1:0] MODULUS_RST = FIELD_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_TEST,
		ST_MUL,
		ST_DONE
	} eoim_state_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic coprime;
	} gcd_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

endpackage

/* src/eoim_gcd.sv */
// ----------------------------------------------------------------------------
// eoim_gcd
// Binary gcd unit: one shift or subtract per cycle, reports coprimality.
// ----------------------------------------------------------------------------
module eoim_gcd (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [eoim_pkg::MOD_BITS-1:0] u_in,
	input  logic [eoim_pkg::MOD_BITS-1:0] v_in,
	output eoim_pkg::gcd_stat_t          stat
);
	import eoim_pkg::*;

	logic [MOD_BITS-1:0] u_q, v_q;
	logic                busy_q, done_q, coprime_q;
	logic                finish, result;

	// both operands nonzero on start, so neither ever reaches zero
	always_comb begin
		finish = 1'b0;
		result = 1'b0;
		if (u_q == v_q) begin
			finish = 1'b1;
			result = (u_q == MOD_BITS'(1));
		end else if (!u_q[0] && !v_q[0]) begin
			finish = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			coprime_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && finish) begin
				busy_q    <= 1'b0;
				done_q    <= 1'b1;
				coprime_q <= result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= u_in;
			v_q <= v_in;
		end else if (busy_q && !finish) begin
			if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q > v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	assign stat.busy    = busy_q;
	assign stat.done    = done_q;
	assign stat.coprime = coprime_q;

endmodule

/* src/eoim_modmul.sv */
// ----------------------------------------------------------------------------
// eoim_modmul
// Bit-serial modular multiplier, multiplier bits MSB first, one per cycle.
// ----------------------------------------------------------------------------
module eoim_modmul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [eoim_pkg::MOD_BITS-1:0] x,
	input  logic [eoim_pkg::MOD_BITS-1:0] y,
	input  logic [eoim_pkg::MOD_BITS-1:0] n,
	output eoim_pkg::mul_stat_t           stat,
	output logic [eoim_pkg::MOD_BITS-1:0] product
);
	import eoim_pkg::*;

	logic [MOD_BITS-1:0] x_q, y_sh_q, r_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q, done_q;
	logic [MOD_BITS:0]   dbl, acc;

	// r <- 2r + bit*x mod n, each partial kept below n
	always_comb begin
		dbl = {r_q, 1'b0};
		if (dbl >= {1'b0, n}) begin
			dbl = dbl - {1'b0, n};
		end
		acc = dbl + (y_sh_q[MOD_BITS-1] ? {1'b0, x_q} : '0);
		if (acc >= {1'b0, n}) begin
			acc = acc - {1'b0, n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			y_sh_q <= y;
			r_q    <= '0;
		end else if (busy_q) begin
			y_sh_q <= y_sh_q << 1;
			r_q    <= acc[MOD_BITS-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = r_q;

endmodule

/* src/element_order_and_inverse_mod_n_core.sv */
// ----------------------------------------------------------------------------
// element_order_and_inverse_mod_n_core
// Multiplicative order and inverse of an element modulo a configured n.
// ----------------------------------------------------------------------------
// Each input word carries one element a. The core returns one result word:
// a flag that a lies in 1..n-1 and is coprime to n, the order k (smallest
// k with a^k = 1 mod n) and the inverse a^(k-1) mod n; order and inverse
// read 0 when the flag is clear. One element is worked on at a time and
// the time per element depends on the data: a range test at accept, the
// binary gcd unit (one shift or subtract per cycle, every subtract followed
// by a shift), then one pass of the bit-serial modular multiplier for every
// power step (k up to n-1). Out-of-range elements skip gcd and powers. The
// multiplier loop sets the rate. A finished result sits in the output
// register while the next element is already taken in. The modulus is
// written through cfg_wen/cfg_wdata; the user must do so only while the
// core is idle, which the core does not enforce; reset value 2.
// ----------------------------------------------------------------------------
module element_order_and_inverse_mod_n_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: modulus
	input  logic                         cfg_wen,
	input  logic [eoim_pkg::FIELD_W-1:0] cfg_wdata,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [eoim_pkg::FIELD_W-1:0] s_tdata,   // [15:0] element
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [2*eoim_pkg::FIELD_W-1:0] m_tdata, // [15:0] order, [31:16] inverse
	output logic [0:0]                   m_tuser    // [0] valid_res
);
	import eoim_pkg::*;

	`include "assert_macros.svh"

	eoim_state_t state_q, state_d;

	logic [FIELD_W-1:0]  modulus_q;
	logic [MOD_BITS-1:0] n;

	// working registers of the power walk
	logic [MOD_BITS-1:0] a_q, p_q, prev_q, k_q;
	// finished result, waiting for the output register
	logic                res_ok_q;
	logic [MOD_BITS-1:0] res_order_q, res_inv_q;

	// output register
	logic                out_valid_q, out_ok_q;
	logic [FIELD_W-1:0]  out_order_q, out_inv_q;

	logic [MOD_BITS-1:0] a_in;
	logic                in_acc, in_range;
	logic                gcd_start, mul_start, load_out, p_is_one, k_at_bound;

	gcd_stat_t           gcd_st;
	mul_stat_t           mul_st;
	logic [MOD_BITS-1:0] mul_prod;

	assign n = MOD_BITS'(modulus_q);

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
		end else if (cfg_wen) begin
			modulus_q <= cfg_wdata;
		end
	end

	// range test at accept: upper element bits beyond the datapath must be
	// clear, then 1 <= a < n (an n below two fails for every a)
	assign a_in     = MOD_BITS'(s_tdata);
	assign in_acc   = s_tvalid && s_tready;
	assign in_range = ((s_tdata >> MOD_BITS) == '0) && (a_in != '0) && (a_in < n);

	assign p_is_one   = (p_q == MOD_BITS'(1));
	assign k_at_bound = (k_q >= n);

	eoim_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.u_in   (n),
		.v_in   (a_in),
		.stat   (gcd_st)
	);

	eoim_modmul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (p_q),
		.y       (a_q),
		.n       (n),
		.stat    (mul_st),
		.product (mul_prod)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = in_range ? ST_GCD : ST_DONE;
				end
			end
			ST_GCD: begin
				if (gcd_st.done) begin
					state_d = gcd_st.coprime ? ST_TEST : ST_DONE;
				end
			end
			ST_TEST: begin
				state_d = (p_is_one || k_at_bound) ? ST_DONE : ST_MUL;
			end
			ST_MUL: begin
				if (mul_st.done) begin
					state_d = ST_TEST;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		gcd_start = 1'b0;
		mul_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				gcd_start = s_tvalid && in_range;
			end
			ST_TEST: mul_start = !p_is_one && !k_at_bound;
			ST_DONE: load_out  = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// power walk: p = a^k, prev = a^(k-1); stops when p reaches 1 or k reaches n
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					a_q         <= a_in;
					res_ok_q    <= 1'b0;
					res_order_q <= '0;
					res_inv_q   <= '0;
				end
			end
			ST_GCD: begin
				if (gcd_st.done) begin
					p_q    <= a_q;
					prev_q <= MOD_BITS'(1);
					k_q    <= MOD_BITS'(1);
				end
			end
			ST_TEST: begin
				if (p_is_one) begin
					res_ok_q    <= 1'b1;
					res_order_q <= k_q;
					res_inv_q   <= prev_q;
				end else if (!k_at_bound) begin
					prev_q <= p_q;
				end
			end
			ST_MUL: begin
				if (mul_st.done) begin
					p_q <= mul_prod;
					k_q <= k_q + MOD_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ok_q    <= res_ok_q;
			out_order_q <= FIELD_W'(res_order_q);
			out_inv_q   <= FIELD_W'(res_inv_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_inv_q, out_order_q};
	assign m_tuser  = out_ok_q;

	// a taken word keeps the input closed until its result is loaded into the output register
	`ASSERT_NEXT(a_in_closed, clk, arst_n, in_acc, !s_tready, "input open right after accept")
	// gcd unit and multiplier never run at the same time
	`ASSERT_ALWAYS(a_units_excl, clk, arst_n, !(gcd_st.busy && mul_st.busy), "gcd and mul both busy")
	// a valid result has a nonzero order and inverse
	`ASSERT_IMPL(a_ok_fields, clk, arst_n, m_tvalid && m_tuser[0], (out_order_q != '0) && (out_inv_q != '0), "valid result with zero field")
	// an invalid result carries zeros
	`ASSERT_IMPL(a_bad_fields, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0, "invalid result with nonzero data")

endmodule
